FILE: rtl/core/lif_pkg.sv
`timescale 1ns / 1ps
// lif_pkg: widths, register codes, reset values and record types for the
// leaky integrate-and-fire neuron block; no dependencies

package lif_pkg;

  localparam int VOLT_W      = 16;
  localparam int RATE_W      = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int FRAC_W      = 8;
  localparam int PROD_W      = RATE_W + 1 + VOLT_W;
  localparam int WIDE_W      = PROD_W - FRAC_W;
  localparam int LIF_STEPS   = 10;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TIME_STEP         = 3'd0,
    REG_MEMBRANE_RATE     = 3'd1,
    REG_SYNAPSE_RATE      = 3'd2,
    REG_LEAK_VOLTAGE      = 3'd3,
    REG_THRESHOLD_VOLTAGE = 3'd4,
    REG_RESET_VOLTAGE     = 3'd5
  } cfg_index_t;

  typedef logic signed [VOLT_W-1:0] volt_t;
  typedef logic [RATE_W-1:0]        rate_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  localparam rate_t RST_TIME_STEP         = 16'd66;
  localparam rate_t RST_MEMBRANE_RATE     = 16'd25600;
  localparam rate_t RST_SYNAPSE_RATE      = 16'd51200;
  localparam volt_t RST_LEAK_VOLTAGE      = 16'sd0;
  localparam volt_t RST_THRESHOLD_VOLTAGE = 16'sd256;
  localparam volt_t RST_RESET_VOLTAGE     = 16'sd0;

  localparam volt_t VOLT_MAX = 16'sh7fff;
  localparam volt_t VOLT_MIN = -16'sh8000;

  // settings seen by every step stage
  typedef struct packed {
    volt_t leak_voltage;
    volt_t threshold_voltage;
    volt_t reset_voltage;
    rate_t membrane_coef;
    rate_t synapse_coef;
  } cfg_t;

  // neuron state between two steps
  typedef struct packed {
    logic  valid;
    logic  spike;
    volt_t v;
    volt_t i;
    volt_t x;
  } step_t;

  // state halfway through a step, products taken
  typedef struct packed {
    logic  valid;
    volt_t v;
    volt_t i;
    volt_t x;
    prod_t pa;
    prod_t pi;
  } mid_t;

  function automatic volt_t sat16(input wide_t x);
    volt_t r;
    if (x > wide_t'(VOLT_MAX)) begin
      r = VOLT_MAX;
    end else if (x < wide_t'(VOLT_MIN)) begin
      r = VOLT_MIN;
    end else begin
      r = volt_t'(x);
    end
    return r;
  endfunction

  // drop the fraction bits, rounding toward minus infinity
  function automatic wide_t floor_q8(input prod_t p);
    return $signed(p[PROD_W-1:FRAC_W]);
  endfunction

endpackage

FILE: rtl/core/lif_if.sv
`timescale 1ns / 1ps
// lif_in_if and lif_out_if: valid/ready channels for input currents and spikes
// depends on lif_pkg

interface lif_in_if;
  import lif_pkg::*;
  logic  valid;
  logic  ready;
  volt_t input_current;
  modport source(output valid, output input_current, input ready);
  modport sink(input valid, input input_current, output ready);
endinterface

interface lif_out_if;
  logic valid;
  logic ready;
  logic spike;
  modport source(output valid, output spike, input ready);
  modport sink(input valid, input spike, output ready);
endinterface

FILE: rtl/core/lif_front.sv
`timescale 1ns / 1ps
// lif_front: register file, coefficient products and input holding register
// depends on lif_pkg, lif_if

module lif_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [lif_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lif_pkg::CFG_DATA_W-1:0]  cfg_data,
  lif_in_if.sink                          in_ch,
  lif_in_if.source                        fwd_ch,
  output lif_pkg::cfg_t                   cfg
);
  import lif_pkg::*;

  rate_t time_step;
  rate_t membrane_rate;
  rate_t synapse_rate;
  volt_t leak_voltage;
  volt_t threshold_voltage;
  volt_t reset_voltage;
  rate_t membrane_coef;
  rate_t synapse_coef;
  logic  hold_valid;
  volt_t hold_data;
  logic [2*RATE_W-1:0] membrane_prod;
  logic [2*RATE_W-1:0] synapse_prod;

  assign in_ch.ready          = !hold_valid || fwd_ch.ready;
  assign fwd_ch.valid         = hold_valid;
  assign fwd_ch.input_current = hold_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid        <= 1'b0;
      time_step         <= RST_TIME_STEP;
      membrane_rate     <= RST_MEMBRANE_RATE;
      synapse_rate      <= RST_SYNAPSE_RATE;
      leak_voltage      <= RST_LEAK_VOLTAGE;
      threshold_voltage <= RST_THRESHOLD_VOLTAGE;
      reset_voltage     <= RST_RESET_VOLTAGE;
    end else begin
      if (in_ch.ready) begin
        hold_valid <= in_ch.valid;
      end
      if (cfg_write) begin
        unique case (cfg_index)
          REG_TIME_STEP:         time_step         <= cfg_data;
          REG_MEMBRANE_RATE:     membrane_rate     <= cfg_data;
          REG_SYNAPSE_RATE:      synapse_rate      <= cfg_data;
          REG_LEAK_VOLTAGE:      leak_voltage      <= $signed(cfg_data);
          REG_THRESHOLD_VOLTAGE: threshold_voltage <= $signed(cfg_data);
          REG_RESET_VOLTAGE:     reset_voltage     <= $signed(cfg_data);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      hold_data <= in_ch.input_current;
    end
  end

  // dt times rate, q0.16 by q8.8, keep q8.8
  assign membrane_prod = (2*RATE_W)'(time_step) * (2*RATE_W)'(membrane_rate);
  assign synapse_prod  = (2*RATE_W)'(time_step) * (2*RATE_W)'(synapse_rate);

  always_ff @(posedge clk) begin
    membrane_coef <= membrane_prod[2*RATE_W-1:RATE_W];
    synapse_coef  <= synapse_prod[2*RATE_W-1:RATE_W];
  end

  always_comb begin
    cfg.leak_voltage      = leak_voltage;
    cfg.threshold_voltage = threshold_voltage;
    cfg.reset_voltage     = reset_voltage;
    cfg.membrane_coef     = membrane_coef;
    cfg.synapse_coef      = synapse_coef;
  end

endmodule

FILE: rtl/core/lif_queue.sv
`timescale 1ns / 1ps
// lif_queue: short register queue between the front and the step pipeline
// depends on lif_pkg, lif_if

module lif_queue (
  input  logic     clk,
  input  logic     rst,
  lif_in_if.sink   push_ch,
  lif_in_if.source pop_ch
);
  import lif_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  volt_t            entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ch.ready        = count != CNT_W'(QUEUE_DEPTH);
  assign pop_ch.valid         = count != '0;
  assign pop_ch.input_current = entries[rd_ptr];
  assign push                 = push_ch.valid && push_ch.ready;
  assign pop                  = pop_ch.valid && pop_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_ch.input_current;
    end
  end

endmodule

FILE: rtl/core/lif_step.sv
`timescale 1ns / 1ps
// lif_step: one euler step of the neuron in two register stages
// depends on lif_pkg

module lif_step (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  lif_pkg::cfg_t  cfg,
  input  lif_pkg::step_t in_step,
  output lif_pkg::step_t out_step
);
  import lif_pkg::*;

  mid_t  mid;
  mid_t  mid_next;
  step_t out_next;
  volt_t diff_sat;
  volt_t drive_sat;
  volt_t dv;
  volt_t vd;
  volt_t di;
  volt_t i_dec;
  logic  fire;

  // first half: leak drive and both products
  always_comb begin
    diff_sat       = sat16(wide_t'(cfg.leak_voltage) - wide_t'(in_step.v));
    drive_sat      = sat16(wide_t'(diff_sat) + wide_t'(in_step.i));
    mid_next.valid = in_step.valid;
    mid_next.v     = in_step.v;
    mid_next.i     = in_step.i;
    mid_next.x     = in_step.x;
    mid_next.pa    = prod_t'($signed({1'b0, cfg.membrane_coef})) * prod_t'(drive_sat);
    mid_next.pi    = prod_t'($signed({1'b0, cfg.synapse_coef})) * prod_t'(in_step.i);
  end

  // second half: voltage update, spike test, current update
  always_comb begin
    dv             = sat16(floor_q8(mid.pa));
    vd             = sat16(wide_t'(mid.v) + wide_t'(dv));
    fire           = vd > cfg.threshold_voltage;
    di             = sat16(floor_q8(mid.pi));
    i_dec          = sat16(wide_t'(mid.i) - wide_t'(di));
    out_next.valid = mid.valid;
    out_next.spike = fire;
    out_next.v     = fire ? cfg.reset_voltage : vd;
    out_next.i     = sat16(wide_t'(i_dec) + wide_t'(mid.x));
    out_next.x     = mid.x;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid.valid      <= 1'b0;
      out_step.valid <= 1'b0;
    end else if (en) begin
      mid      <= mid_next;
      out_step <= out_next;
    end
  end

endmodule

FILE: rtl/core/lif_back.sv
`timescale 1ns / 1ps
// lif_back: chain of step stages and the output register
// depends on lif_pkg, lif_if, lif_step

module lif_back #(
  parameter int STEPS = lif_pkg::LIF_STEPS
) (
  input  logic          clk,
  input  logic          rst,
  input  lif_pkg::cfg_t cfg,
  lif_in_if.sink        deq_ch,
  lif_out_if.source     out_ch
);
  import lif_pkg::*;

  step_t chain [STEPS+1];
  logic  advance;

  assign advance      = !out_ch.valid || out_ch.ready;
  assign deq_ch.ready = advance;

  // every item starts at zero voltage and zero current
  always_comb begin
    chain[0].valid = deq_ch.valid;
    chain[0].spike = 1'b0;
    chain[0].v     = '0;
    chain[0].i     = '0;
    chain[0].x     = deq_ch.input_current;
  end

  for (genvar g = 0; g < STEPS; g++) begin : g_step
    lif_step u_step (
      .clk      (clk),
      .rst      (rst),
      .en       (advance),
      .cfg      (cfg),
      .in_step  (chain[g]),
      .out_step (chain[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (advance) begin
      out_ch.valid <= chain[STEPS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_ch.spike <= chain[STEPS].spike;
    end
  end

endmodule

FILE: rtl/core/lif_neuron_spike_step.sv
`timescale 1ns / 1ps
// lif_neuron_spike_step: top level of the leaky integrate-and-fire neuron
// depends on lif_pkg, lif_if, lif_front, lif_queue, lif_back
//
//   channel      dir  beat content                  handshake
//   in_stream    in   input_current, signed q8.8    valid / ready
//   out_stream   out  spike, 1 bit                  valid / ready
//   cfg          in   cfg_index, cfg_data (16 bit)  cfg_write, no back-pressure
//
// one beat per cycle in and out while out_stream is ready; a beat's spike passes
// through the holding register, a queue slot, two register stages per euler
// step (one multiplier pair per step) and the output register
// rst is synchronous: registers return to their reset values, queue and
// pipeline empty
// out_stream back-pressure freezes the step chain; the queue and holding
// register keep taking beats until full

module lif_neuron_spike_step #(
  parameter int STEPS = lif_pkg::LIF_STEPS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [lif_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lif_pkg::CFG_DATA_W-1:0]  cfg_data,
  lif_in_if.sink                          in_stream,
  lif_out_if.source                       out_stream
);
  import lif_pkg::*;

  // front to queue, queue to step chain
  lif_in_if fwd_if ();
  lif_in_if deq_if ();

  // register values and coefficients; the user keeps them static while beats are in flight, not enforced by the block
  cfg_t cfg;

  lif_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_stream),
    .fwd_ch    (fwd_if.source),
    .cfg       (cfg)
  );

  // decouples the front from stalls in the step chain
  lif_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push_ch (fwd_if.sink),
    .pop_ch  (deq_if.source)
  );

  lif_back #(
    .STEPS (STEPS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .deq_ch (deq_if.sink),
    .out_ch (out_stream)
  );

endmodule

FILE: tb/tb_lif_neuron_spike_step.sv
`timescale 1ns / 1ps
// tb_lif_neuron_spike_step: self-checking bench for the leaky integrate-and-fire
// spike block; a directed table, then random phases with new settings
// depends on lif_pkg, lif_if and the lif_neuron_spike_step rtl

module tb_lif_neuron_spike_step;
  import lif_pkg::*;

  // settle time after a drain: the depth of the block's pipeline plus a margin
  localparam int SETTLE_CYCLES  = 2 * LIF_STEPS + 10;
  localparam int RANDOM_BEATS   = 1100;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int CYCLE_LIMIT    = 400000;

  // register indexes the block does not decode, written to check they are ignored
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;
  // index field of a table row that carries a beat, not a write
  localparam logic [CFG_INDEX_W-1:0] NO_INDEX     = 3'd0;

  localparam logic TYPED     = 1'b1;
  localparam logic PREDICTED = 1'b0;

  typedef enum logic {
    ROW_WRITE,
    ROW_BEAT
  } row_kind_t;

  // one row of the directed table: a register write or an input beat;
  // for a beat, data is the current and spike is the hand-typed answer
  typedef struct packed {
    row_kind_t                kind;
    logic [CFG_INDEX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]    data;
    logic                     typed;
    logic                     spike;
  } row_t;

  localparam int N_DIRECTED = 39;
  localparam row_t DIRECTED [N_DIRECTED] = '{
    // reset settings: rest, full drive and full inhibition
    '{ROW_BEAT,  NO_INDEX,              16'h0000, TYPED,     1'b0},
    '{ROW_BEAT,  NO_INDEX,              16'h7fff, TYPED,     1'b1},
    '{ROW_BEAT,  NO_INDEX,              16'h8000, TYPED,     1'b0},
    '{ROW_BEAT,  NO_INDEX,              16'h0001, PREDICTED, 1'b0},
    '{ROW_BEAT,  NO_INDEX,              16'hffff, PREDICTED, 1'b0},
    '{ROW_BEAT,  NO_INDEX,              16'h0100, PREDICTED, 1'b0},
    '{ROW_BEAT,  NO_INDEX,              16'hff00, PREDICTED, 1'b0},
    '{ROW_BEAT,  NO_INDEX,              16'h5555, PREDICTED, 1'b0},
    '{ROW_BEAT,  NO_INDEX,              16'haaaa, PREDICTED, 1'b0},
    '{ROW_BEAT,  NO_INDEX,              16'h0a00, PREDICTED, 1'b0},
    // writes to undecoded indexes must leave every setting alone
    '{ROW_WRITE, REG_SPARE_LO,          16'hffff, PREDICTED, 1'b0},
    '{ROW_WRITE, REG_SPARE_HI,          16'h1234, PREDICTED, 1'b0},
    '{ROW_BEAT,  NO_INDEX,              16'h0000, TYPED,     1'b0},
    '{ROW_BEAT,  NO_INDEX,              16'h7fff, TYPED,     1'b1},
    // threshold at the top: a strict compare can never pass
    '{ROW_WRITE, REG_THRESHOLD_VOLTAGE, 16'h7fff, PREDICTED, 1'b0},
    '{ROW_BEAT,  NO_INDEX,              16'h7fff, TYPED,     1'b0},
    '{ROW_BEAT,  NO_INDEX,              16'h8000, TYPED,     1'b0},
    // threshold at the bottom: a resting neuron fires on every step
    '{ROW_WRITE, REG_THRESHOLD_VOLTAGE, 16'h8000, PREDICTED, 1'b0},
    '{ROW_BEAT,  NO_INDEX,              16'h0000, TYPED,     1'b1},
    '{ROW_BEAT,  NO_INDEX,              16'h8000, PREDICTED, 1'b0},
    // every rate at its top, leak high, reset voltage low
    '{ROW_WRITE, REG_TIME_STEP,         16'hffff, PREDICTED, 1'b0},
    '{ROW_WRITE, REG_MEMBRANE_RATE,     16'hffff, PREDICTED, 1'b0},
    '{ROW_WRITE, REG_SYNAPSE_RATE,      16'hffff, PREDICTED, 1'b0},
    '{ROW_WRITE, REG_LEAK_VOLTAGE,      16'h7fff, PREDICTED, 1'b0},
    '{ROW_WRITE, REG_THRESHOLD_VOLTAGE, 16'h0000, PREDICTED, 1'b0},
    '{ROW_WRITE, REG_RESET_VOLTAGE,     16'h8000, PREDICTED, 1'b0},
    '{ROW_BEAT,  NO_INDEX,              16'h7fff, PREDICTED, 1'b0},
    '{ROW_BEAT,  NO_INDEX,              16'h8000, PREDICTED, 1'b0},
    '{ROW_BEAT,  NO_INDEX,              16'h0000, PREDICTED, 1'b0},
    '{ROW_BEAT,  NO_INDEX,              16'h1234, PREDICTED, 1'b0},
    // zero step: dv is always zero and v only jumps to the high reset voltage, so with threshold -1 every step fires
    '{ROW_WRITE, REG_TIME_STEP,         16'h0000, PREDICTED, 1'b0},
    '{ROW_WRITE, REG_MEMBRANE_RATE,     16'h0000, PREDICTED, 1'b0},
    '{ROW_WRITE, REG_SYNAPSE_RATE,      16'h0000, PREDICTED, 1'b0},
    '{ROW_WRITE, REG_LEAK_VOLTAGE,      16'h8000, PREDICTED, 1'b0},
    '{ROW_WRITE, REG_THRESHOLD_VOLTAGE, 16'hffff, PREDICTED, 1'b0},
    '{ROW_WRITE, REG_RESET_VOLTAGE,     16'h7fff, PREDICTED, 1'b0},
    '{ROW_BEAT,  NO_INDEX,              16'h7fff, TYPED,     1'b1},
    '{ROW_BEAT,  NO_INDEX,              16'h8000, TYPED,     1'b1},
    '{ROW_BEAT,  NO_INDEX,              16'h00ff, PREDICTED, 1'b0}
  };

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  lif_in_if  in_bus ();
  lif_out_if out_bus ();

  lif_neuron_spike_step u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_stream  (in_bus),
    .out_stream (out_bus)
  );

  // shadow copy of the settings, updated as each write is issued
  rate_t dt_q016;
  rate_t memb_rate;
  rate_t syn_rate;
  volt_t leak_v;
  volt_t thresh_v;
  volt_t reset_v;

  // spikes owed by the block, oldest first
  logic spike_due [$];
  logic want_spike;

  int mismatches;
  int cycle_count;
  int holdoff_asked;
  bit no_idle;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // hard stop in case the block hangs
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic longint clamp_q8(input longint x);
    if (x > longint'(VOLT_MAX)) return longint'(VOLT_MAX);
    if (x < longint'(VOLT_MIN)) return longint'(VOLT_MIN);
    return x;
  endfunction

  // run the neuron from rest for LIF_STEPS euler steps, spike of the last one;
  // >>> on a signed value floors, matching the truncated products
  function automatic logic predict_spike(input volt_t cur);
    longint x, leak, th, vr, cm, cs, v, i, a, dv, vd, di;
    logic fired;
    x     = longint'(cur);
    leak  = longint'(leak_v);
    th    = longint'(thresh_v);
    vr    = longint'(reset_v);
    cm    = (longint'(dt_q016) * longint'(memb_rate)) >>> 16;
    cs    = (longint'(dt_q016) * longint'(syn_rate)) >>> 16;
    v     = 0;
    i     = 0;
    fired = 1'b0;
    for (int n = 0; n < LIF_STEPS; n++) begin
      a     = clamp_q8(clamp_q8(leak - v) + i);
      dv    = clamp_q8((cm * a) >>> 8);
      vd    = clamp_q8(v + dv);
      fired = (vd > th);
      v     = fired ? vr : vd;
      di    = clamp_q8((cs * i) >>> 8);
      i     = clamp_q8(clamp_q8(i - di) + x);
    end
    return fired;
  endfunction

  // mostly back to back, often short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic volt_t pick_current();
    volt_t c;
    case ($urandom_range(0, 3))
      0, 1: c = volt_t'($urandom);
      2: c = volt_t'(int'($urandom_range(0, 1536)) - 768);
      default: begin
        case ($urandom_range(0, 3))
          0: c = VOLT_MAX;
          1: c = VOLT_MIN;
          2: c = '0;
          default: c = '1;
        endcase
      end
    endcase
    return c;
  endfunction

  // extremes often, otherwise full range or values near the useful region
  function automatic logic [CFG_DATA_W-1:0] pick_reg_value(input logic [CFG_INDEX_W-1:0] idx);
    logic [CFG_DATA_W-1:0] val;
    case ($urandom_range(0, 9))
      0: val = 16'h0000;
      1: val = 16'hffff;
      2: val = 16'h7fff;
      3: val = 16'h8000;
      4, 5: val = 16'($urandom);
      default: begin
        case (idx)
          REG_TIME_STEP: val = 16'($urandom_range(1, 2048));
          REG_MEMBRANE_RATE, REG_SYNAPSE_RATE: val = 16'($urandom_range(0, 65535));
          default: val = 16'(int'($urandom_range(0, 2048)) - 1024);
        endcase
      end
    endcase
    return val;
  endfunction

  // leaves cfg_write high so writes can run back to back; caller lowers it
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_TIME_STEP:         dt_q016   = data;
      REG_MEMBRANE_RATE:     memb_rate = data;
      REG_SYNAPSE_RATE:      syn_rate  = data;
      REG_LEAK_VOLTAGE:      leak_v    = data;
      REG_THRESHOLD_VOLTAGE: thresh_v  = data;
      REG_RESET_VOLTAGE:     reset_v   = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // offer one beat, wait for the handshake, then book the spike it owes;
  // valid stays high on return so the next beat can follow without a gap
  task automatic send_beat(input volt_t cur, input logic typed, input logic typed_spike);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid         <= 1'b1;
    in_bus.input_current <= cur;
    do @(posedge clk); while (!in_bus.ready);
    spike_due.push_back(typed ? typed_spike : predict_spike(cur));
  endtask

  // stop offering, wait for every owed spike, then let the pipe settle
  task automatic drain();
    in_bus.valid <= 1'b0;
    while (spike_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // receiver: random stalls, plus a long hold-off whenever one is asked for
  initial begin
    int stall;
    int holdoff;
    int holdoff_done;
    stall        = 0;
    holdoff      = 0;
    holdoff_done = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_done != holdoff_asked) begin
        holdoff      = HOLDOFF_CYCLES;
        holdoff_done = holdoff_asked;
      end
      if (holdoff > 0) begin
        out_bus.ready <= 1'b0;
        holdoff--;
      end else if (stall > 0) begin
        out_bus.ready <= 1'b0;
        stall--;
      end else begin
        out_bus.ready <= 1'b1;
        if (!no_idle) stall = pick_gap();
      end
    end
  end

  // result checker: each spike beat against the oldest owed spike
  always @(posedge clk) begin
    if (!rst && out_bus.valid && out_bus.ready) begin
      if (spike_due.size() == 0) begin
        $error("spike: expected nothing, actual %0b", out_bus.spike);
        mismatches++;
      end else begin
        want_spike = spike_due.pop_front();
        if (out_bus.spike !== want_spike) begin
          $error("spike: expected %0b, actual %0b", want_spike, out_bus.spike);
          mismatches++;
        end
      end
    end
  end

  // main sequence
  initial begin
    row_t row;
    logic cfg_active;
    int   k;
    int   pass_no;
    int   burst;
    int   sent;
    mismatches    = 0;
    holdoff_asked = 0;
    no_idle       = 1'b0;
    dt_q016       = RST_TIME_STEP;
    memb_rate     = RST_MEMBRANE_RATE;
    syn_rate      = RST_SYNAPSE_RATE;
    leak_v        = RST_LEAK_VOLTAGE;
    thresh_v      = RST_THRESHOLD_VOLTAGE;
    reset_v       = RST_RESET_VOLTAGE;
    rst                  <= 1'b1;
    cfg_write            <= 1'b0;
    cfg_index            <= '0;
    cfg_data             <= '0;
    in_bus.valid         <= 1'b0;
    in_bus.input_current <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed table: a run of writes starts only once the pipe is empty
    cfg_active = 1'b0;
    for (k = 0; k < N_DIRECTED; k++) begin
      row = DIRECTED[k];
      if (row.kind == ROW_WRITE) begin
        if (!cfg_active) begin
          drain();
          cfg_active = 1'b1;
        end
        write_reg(row.idx, row.data);
      end else begin
        if (cfg_active) begin
          cfg_write <= 1'b0;
          cfg_active = 1'b0;
        end
        send_beat(volt_t'(row.data), row.typed, row.spike);
      end
    end

    // random passes: new settings while idle, then a burst of beats
    pass_no = 0;
    sent    = 0;
    while (sent < RANDOM_BEATS) begin
      drain();
      for (int r = REG_TIME_STEP; r <= REG_RESET_VOLTAGE; r++) begin
        if (pass_no == 0 || $urandom_range(0, 2) != 0) begin
          write_reg(CFG_INDEX_W'(r), pick_reg_value(CFG_INDEX_W'(r)));
        end
      end
      if ($urandom_range(0, 4) == 0) begin
        write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, 16'($urandom));
      end
      cfg_write <= 1'b0;

      // some passes run with no idling on either side
      no_idle = ($urandom_range(0, 3) == 0);
      // twice the receiver stops for a long stretch while beats keep coming,
      // so the queue and holding register fill and ready drops
      if (pass_no == 3 || pass_no == 9) begin
        no_idle = 1'b1;
        holdoff_asked++;
      end

      burst = $urandom_range(30, 110);
      for (k = 0; k < burst && sent < RANDOM_BEATS; k++) begin
        send_beat(pick_current(), PREDICTED, 1'b0);
        sent++;
        // sender pauses now and then until every spike is back
        if ($urandom_range(0, 59) == 0) drain();
      end
      pass_no++;
    end

    drain();
    if (mismatches == 0 && spike_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
